/* rtl/vth_pkg.sv */
`default_nettype none
package vth_pkg;

  parameter int FRAC_BITS_DEF = 16;
  parameter int DATA_W        = 32;
  parameter int N_REGS        = 8;
  parameter int REG_W         = 64;
  parameter int IDX_W         = 4;
  parameter int N_COLS        = 4;
  parameter int N_LANES       = 3;
  parameter int DIV_STEPS     = 32;
  // Signed column sums and their magnitudes.
  parameter int SUM_W         = 66;
  parameter int MAG_W         = 65;
  parameter int QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic                     point;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } item_t;

  typedef logic [REG_W-1:0] mat_t [N_REGS];

  // Saturate a magnitude to a 32-bit signed value of the given sign.
  function automatic logic [DATA_W-1:0] sat32(input logic ovf, input logic [DATA_W:0] mag,
                                              input logic neg);
    logic [DATA_W:0] min_mag;
    logic [DATA_W:0] max_mag;
    logic [DATA_W:0] neg_mag;
    min_mag = {2'b01, {(DATA_W-1){1'b0}}};
    max_mag = {2'b00, {(DATA_W-1){1'b1}}};
    neg_mag = -mag;
    if (neg) begin
      if (ovf || mag > min_mag) sat32 = {1'b1, {(DATA_W-1){1'b0}}};
      else sat32 = neg_mag[DATA_W-1:0];
    end else begin
      if (ovf || mag > max_mag) sat32 = {1'b0, {(DATA_W-1){1'b1}}};
      else sat32 = mag[DATA_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/vth_front.sv */
`default_nettype none
module vth_front
  import vth_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               req_type,
  input  wire  [DATA_W-1:0] vx,
  input  wire  [DATA_W-1:0] vy,
  input  wire  [DATA_W-1:0] vz,
  output logic              item_valid,
  input  wire               item_ready,
  output item_t             item
);

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Request type zero is a point: translation row and perspective divide.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.point <= !req_type;
      item_r.x     <= vx;
      item_r.y     <= vy;
      item_r.z     <= vz;
    end
  end

endmodule
`default_nettype wire

/* rtl/vth_queue.sv */
`default_nettype none
module vth_queue
  import vth_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  wire   rd_ready,
  output item_t rd_item,
  output logic  [1:0] count
);

  item_t      mem_r [QUEUE_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = count_r != 2'(QUEUE_DEPTH);
  assign rd_valid = count_r != 2'd0;
  assign rd_item  = mem_r[rd_ptr_r];
  assign count    = count_r;
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_item;
  end

endmodule
`default_nettype wire

/* rtl/vth_back.sv */
`default_nettype none
module vth_back
  import vth_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  mat_t              mat,
  input  wire               in_valid,
  output logic              in_ready,
  input  item_t             in_item,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [DATA_W-1:0] out_x,
  output logic [DATA_W-1:0] out_y,
  output logic [DATA_W-1:0] out_z,
  output logic              out_w_zero
);

  localparam int N_STG = 5 + DIV_STEPS + 1;
  localparam int RSH   = DATA_W - FRAC_BITS;

  logic             en;
  logic [N_STG-1:0] vld_r;

  assign en        = !vld_r[N_STG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[N_STG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N_STG-2:0], in_valid};
    end
  end

  // Stage 1: the nine products of the upper 3x3 block plus the w column.
  logic signed [DATA_W-1:0] vin   [N_LANES];
  logic signed [DATA_W-1:0] el    [N_COLS][N_COLS];
  logic signed [2*DATA_W-1:0] prod_nxt [N_LANES][N_COLS];
  logic signed [2*DATA_W-1:0] prod_r   [N_LANES][N_COLS];
  logic signed [SUM_W-1:0]    tr_nxt   [N_COLS];
  logic signed [SUM_W-1:0]    tr_r     [N_COLS];
  logic point1_r;

  always_comb begin
    vin[0] = in_item.x;
    vin[1] = in_item.y;
    vin[2] = in_item.z;
    for (int r = 0; r < N_COLS; r++) begin
      for (int c = 0; c < N_COLS; c++) begin
        el[r][c] = mat[2*r + c/2][(c%2)*DATA_W +: DATA_W];
      end
    end
    for (int r = 0; r < N_LANES; r++) begin
      for (int c = 0; c < N_COLS; c++) begin
        prod_nxt[r][c] = vin[r] * el[r][c];
      end
    end
    for (int c = 0; c < N_COLS; c++) begin
      tr_nxt[c] = in_item.point ? (SUM_W'(el[3][c]) <<< FRAC_BITS) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      tr_r     <= tr_nxt;
      point1_r <= in_item.point;
    end
  end

  // Stages 2 and 3: column sums in two adder levels.
  logic signed [SUM_W-1:0] a_r [N_COLS];
  logic signed [SUM_W-1:0] b_r [N_COLS];
  logic signed [SUM_W-1:0] s_r [N_COLS];
  logic point2_r, point3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < N_COLS; c++) begin
        a_r[c] <= SUM_W'(prod_r[0][c]) + SUM_W'(prod_r[1][c]);
        b_r[c] <= SUM_W'(prod_r[2][c]) + tr_r[c];
        s_r[c] <= a_r[c] + b_r[c];
      end
      point2_r <= point1_r;
      point3_r <= point2_r;
    end
  end

  // Stage 4: sign and magnitude.
  logic [MAG_W-1:0] mag_r [N_COLS];
  logic             sgn_r [N_COLS];
  logic [SUM_W-1:0] ns    [N_COLS];
  logic point4_r, wz4_r;

  always_comb begin
    for (int c = 0; c < N_COLS; c++) ns[c] = s_r[c][SUM_W-1] ? -s_r[c] : s_r[c];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < N_COLS; c++) begin
        mag_r[c] <= ns[c][MAG_W-1:0];
        sgn_r[c] <= s_r[c][SUM_W-1];
      end
      point4_r <= point3_r;
      wz4_r    <= point3_r && (s_r[3] == '0);
    end
  end

  // Stage 5: direction rounding, divide overflow check and divider setup.
  // Divider pipeline arrays: index 0 is the stage 5 output.
  logic [MAG_W-1:0]  rem_r [DIV_STEPS+1][N_LANES];
  logic [DATA_W-1:0] q_r   [DIV_STEPS+1][N_LANES];
  logic [DATA_W-1:0] nl_r  [DIV_STEPS+1][N_LANES];
  logic              ovf_r [DIV_STEPS+1][N_LANES];
  logic              neg_r [DIV_STEPS+1][N_LANES];
  logic [DATA_W-1:0] dres_r[DIV_STEPS+1][N_LANES];
  logic [MAG_W-1:0]  den_r [DIV_STEPS+1];
  logic              pt_r  [DIV_STEPS+1];
  logic              wz_r  [DIV_STEPS+1];

  logic [MAG_W:0]         rnd   [N_LANES];
  logic [MAG_W+DATA_W-1:0] numx [N_LANES];
  logic [MAG_W+DATA_W-1:0] denx;
  logic [MAG_W-1:0]       nsh   [N_LANES];

  always_comb begin
    denx = {mag_r[3], {DATA_W{1'b0}}};
    for (int l = 0; l < N_LANES; l++) begin
      rnd[l]  = ({1'b0, mag_r[l]} + (MAG_W+1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
      numx[l] = (MAG_W+DATA_W)'({mag_r[l], {FRAC_BITS{1'b0}}});
      nsh[l]  = mag_r[l] << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < N_LANES; l++) begin
        dres_r[0][l] <= sat32(|rnd[l][MAG_W:DATA_W+1], rnd[l][DATA_W:0], sgn_r[l]);
        ovf_r[0][l]  <= numx[l] >= denx;
        neg_r[0][l]  <= sgn_r[l] ^ sgn_r[3];
        rem_r[0][l]  <= mag_r[l] >> RSH;
        nl_r[0][l]   <= nsh[l][DATA_W-1:0];
        q_r[0][l]    <= '0;
      end
      den_r[0] <= mag_r[3];
      pt_r[0]  <= point4_r;
      wz_r[0]  <= wz4_r;
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [MAG_W:0] trial [N_LANES];
    logic           ge    [N_LANES];
    logic [MAG_W:0] diff  [N_LANES];

    always_comb begin
      for (int l = 0; l < N_LANES; l++) begin
        trial[l] = {rem_r[k][l], nl_r[k][l][DATA_W-1]};
        ge[l]    = trial[l] >= {1'b0, den_r[k]};
        diff[l]  = trial[l] - {1'b0, den_r[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < N_LANES; l++) begin
          rem_r[k+1][l]  <= ge[l] ? diff[l][MAG_W-1:0] : trial[l][MAG_W-1:0];
          q_r[k+1][l]    <= {q_r[k][l][DATA_W-2:0], ge[l]};
          nl_r[k+1][l]   <= nl_r[k][l] << 1;
          ovf_r[k+1][l]  <= ovf_r[k][l];
          neg_r[k+1][l]  <= neg_r[k][l];
          dres_r[k+1][l] <= dres_r[k][l];
        end
        den_r[k+1] <= den_r[k];
        pt_r[k+1]  <= pt_r[k];
        wz_r[k+1]  <= wz_r[k];
      end
    end
  end

  // Final stage: round to nearest, saturate; directions pass through.
  logic [DATA_W-1:0] res   [N_LANES];
  logic [DATA_W:0]   qr    [N_LANES];
  logic              rup   [N_LANES];

  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      rup[l] = {rem_r[DIV_STEPS][l], 1'b0} >= {1'b0, den_r[DIV_STEPS]};
      qr[l]  = {1'b0, q_r[DIV_STEPS][l]} + (DATA_W+1)'(rup[l]);
      if (!pt_r[DIV_STEPS]) res[l] = dres_r[DIV_STEPS][l];
      else if (wz_r[DIV_STEPS]) res[l] = '0;
      else res[l] = sat32(ovf_r[DIV_STEPS][l], qr[l], neg_r[DIV_STEPS][l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x      <= res[0];
      out_y      <= res[1];
      out_z      <= res[2];
      out_w_zero <= wz_r[DIV_STEPS];
    end
  end

endmodule
`default_nettype wire

/* rtl/vertex_transform_homogeneous_core.sv */
`default_nettype none
// Transforms a signed fixed-point 3-vector by a 4x4 row-vector matrix held in eight
// 64-bit registers (two entries each, row by row, identity after reset). A point
// (in_req_type 0) gets w = 1 appended and x, y, z divided by the resulting w, rounded
// to nearest and saturated; out_w_zero flags a zero w and forces the outputs to zero.
// A direction (in_req_type 1) uses the upper 3x3 only. One transfer is taken every
// cycle while out_ready stays high; the result passes the front register, the queue
// and the one-bit-per-stage restoring divider (32 stages) behind the multiply and
// adder stages. Write the matrix only while the block is idle.
module vertex_transform_homogeneous_core
  import vth_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               in_req_type,
  input  wire  [DATA_W-1:0] in_x,
  input  wire  [DATA_W-1:0] in_y,
  input  wire  [DATA_W-1:0] in_z,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [DATA_W-1:0] out_x,
  output logic [DATA_W-1:0] out_y,
  output logic [DATA_W-1:0] out_z,
  output logic              out_w_zero,
  input  wire               cfg_we,
  input  wire  [IDX_W-1:0]  cfg_index,
  input  wire  [REG_W-1:0]  cfg_data
);

  localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0] ONE_HI = REG_W'(1) << (FRAC_BITS + DATA_W);

  mat_t mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= ONE_LO;
      mat_r[1] <= '0;
      mat_r[2] <= ONE_HI;
      mat_r[3] <= '0;
      mat_r[4] <= '0;
      mat_r[5] <= ONE_LO;
      mat_r[6] <= '0;
      mat_r[7] <= ONE_HI;
    end else if (cfg_we && cfg_index < IDX_W'(N_REGS)) begin
      mat_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  logic       f_valid, f_ready;
  item_t      f_item;
  logic       q_valid, q_ready;
  item_t      q_item;
  logic [1:0] q_count;

  vth_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (in_req_type),
    .vx         (in_x),
    .vy         (in_y),
    .vz         (in_z),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  vth_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item),
    .count    (q_count)
  );

  vth_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mat        (mat_r),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w_zero (out_w_zero)
  );

`ifndef SYNTHESIS
  a_wzero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_zero |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("zero w result with nonzero outputs");
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= 2'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && q_count == 2'd0)
    else $error("result pending after reset");
`endif

endmodule
`default_nettype wire
